### rtl/lfme_pkg.sv
// ----------------------------------------------------------------------------
// lfme_pkg
// Shared types, codes and helpers of the LED frame mirror engine.
// ----------------------------------------------------------------------------
package lfme_pkg;

	localparam int DEF_MAX_WIDTH  = 32;
	localparam int DEF_MAX_HEIGHT = 32;
	localparam int CFG_W          = 6;   // widest configuration register
	localparam int CFG_IDX_W      = 2;
	localparam int DIM_W          = 9;   // holds the largest supported dimension
	localparam int DIM_RESET      = 32;  // register value after reset
	localparam int COLOR_W        = 24;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_MIRROR = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		MODE_HORIZ        = 3'd0,
		MODE_VERT         = 3'd1,
		MODE_QUAD         = 3'd2,
		MODE_QUAD_ROT     = 3'd3,
		MODE_TRI_TOP      = 3'd4,
		MODE_TRI_BOT      = 3'd5,
		MODE_QUAD_TRI_TOP = 3'd6,
		MODE_QUAD_TRI_BOT = 3'd7
	} mode_t;

	// one copy walk of the address generator
	typedef enum logic [2:0] {
		PH_HORIZ   = 3'd0,
		PH_VERT    = 3'd1,
		PH_ROT     = 3'd2,
		PH_TRI_TOP = 3'd3,
		PH_TRI_BOT = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_CLEAR   = 3'd0,
		ST_IDLE    = 3'd1,
		ST_PHASE   = 3'd2,
		ST_COPY_RD = 3'd3,
		ST_COPY_WR = 3'd4
	} state_t;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [7:0]  x;
		logic signed [7:0]  y;
		logic [COLOR_W-1:0] color;
		logic [2:0]         mode;
		logic               full_height;
	} in_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
		logic               on_screen;
	} out_item_t;

	typedef struct packed {
		phase_t phase;
		logic   full;
		logic   last;
	} seq_t;

	// controller -> datapath commands
	typedef struct packed {
		logic   clr_wr;
		logic   px_wr;
		logic   px_rd;
		logic   mir_rd;
		logic   mir_wr;
		logic   g_init;
		logic   g_step;
		phase_t phase;
		logic   full;
	} ctl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic blocked;
	} st_stat_t;

	typedef struct packed {
		logic empty;
		logic last;
	} geo_stat_t;

	// phase list of each mirror mode
	function automatic seq_t seq_step(input mode_t mode, input logic full,
			input logic [1:0] idx);
		seq_t s;
		s = '{phase: PH_VERT, full: 1'b0, last: 1'b1};
		unique case (mode)
			MODE_HORIZ:    s = '{phase: PH_HORIZ, full: full, last: 1'b1};
			MODE_VERT:     s = '{phase: PH_VERT, full: 1'b0, last: 1'b1};
			MODE_QUAD: begin
				if (idx == 2'd0) s = '{phase: PH_HORIZ, full: 1'b0, last: 1'b0};
			end
			MODE_QUAD_ROT: s = '{phase: PH_ROT, full: 1'b0, last: 1'b1};
			MODE_TRI_TOP:  s = '{phase: PH_TRI_TOP, full: full, last: 1'b1};
			MODE_TRI_BOT:  s = '{phase: PH_TRI_BOT, full: full, last: 1'b1};
			MODE_QUAD_TRI_TOP: begin
				if (idx == 2'd0) s = '{phase: PH_TRI_TOP, full: 1'b0, last: 1'b0};
				else if (idx == 2'd1) s = '{phase: PH_HORIZ, full: 1'b0, last: 1'b0};
			end
			MODE_QUAD_TRI_BOT: begin
				if (idx == 2'd0) s = '{phase: PH_TRI_BOT, full: 1'b0, last: 1'b0};
				else if (idx == 2'd1) s = '{phase: PH_HORIZ, full: 1'b0, last: 1'b0};
			end
		endcase
		return s;
	endfunction

	// register value to dimension: 0 reads as 1, large values saturate
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
			input int unsigned maxd);
		logic [DIM_W-1:0] vv;
		vv = DIM_W'(v);
		if (v == '0) return DIM_W'(1);
		else if (vv > DIM_W'(maxd)) return DIM_W'(maxd);
		else return vv;
	endfunction

endpackage

### rtl/lfme_ctrl.sv
// ----------------------------------------------------------------------------
// lfme_ctrl
// Sequencer: clear sweep, pixel access handshake and mirror phase walk.
// ----------------------------------------------------------------------------
module lfme_ctrl import lfme_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	input  st_stat_t  st_stat,
	input  geo_stat_t geo_stat,
	output ctl_cmd_t  cmd
);

	state_t     state_q, state_nxt;
	mode_t      mode_q;
	logic       full_q;
	logic [1:0] pidx_q;
	seq_t       sq;
	logic       accept;
	logic       adv;
	op_t        op;

	assign op     = op_t'(in_data.op);
	assign sq     = seq_step(mode_q, full_q, pidx_q);
	assign accept = (state_q == ST_IDLE) && in_valid && !st_stat.blocked;
	assign adv    = ((state_q == ST_COPY_RD) && geo_stat.empty) ||
	                ((state_q == ST_COPY_WR) && geo_stat.last);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (st_stat.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept && op == OP_MIRROR) state_nxt = ST_PHASE;
			end
			ST_PHASE:   state_nxt = ST_COPY_RD;
			ST_COPY_RD: begin
				if (!geo_stat.empty) state_nxt = ST_COPY_WR;
				else state_nxt = sq.last ? ST_IDLE : ST_PHASE;
			end
			ST_COPY_WR: begin
				if (!geo_stat.last) state_nxt = ST_COPY_RD;
				else state_nxt = sq.last ? ST_IDLE : ST_PHASE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				in_stall   = st_stat.blocked;
				cmd.px_wr  = accept && (op == OP_WRITE);
				cmd.px_rd  = accept && (op == OP_READ);
			end
			ST_PHASE: begin
				cmd.g_init = 1'b1;
				cmd.phase  = sq.phase;
				cmd.full   = sq.full;
			end
			ST_COPY_RD: cmd.mir_rd = !geo_stat.empty;
			ST_COPY_WR: begin
				cmd.mir_wr = 1'b1;
				cmd.g_step = 1'b1;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			mode_q  <= MODE_HORIZ;
			full_q  <= 1'b0;
			pidx_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept && op == OP_MIRROR) begin
				mode_q <= mode_t'(in_data.mode);
				full_q <= in_data.full_height;
				pidx_q <= '0;
			end else if (adv && !sq.last) begin
				pidx_q <= pidx_q + 2'd1;
			end
		end
	end

endmodule

### rtl/lfme_geom.sv
// ----------------------------------------------------------------------------
// lfme_geom
// Active size registers and the copy address generator of the mirror walks.
// ----------------------------------------------------------------------------
module lfme_geom import lfme_pkg::*; #(
	parameter  int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter  int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int CW = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  ctl_cmd_t             cmd,
	output geo_stat_t            geo_stat,
	output logic [CW-1:0]        act_w,
	output logic [CW-1:0]        act_h,
	output logic [CW-1:0]        src_col,
	output logic [CW-1:0]        src_row,
	output logic [CW-1:0]        dst_col,
	output logic [CW-1:0]        dst_row
);

	logic [CW-1:0] w_q, h_q;
	phase_t        ph_q;
	logic          full_q;
	logic [CW-1:0] i_q, j_q;
	logic [1:0]    s_q;

	logic [CW-1:0] half_w, up_w, half_h, up_h, n, mid, lastc, k, m;
	logic [CW-1:0] top, a, b, outer_n, inner_n;
	logic [1:0]    ns;
	logic          s_last, j_last, i_last;

	assign act_w = w_q;
	assign act_h = h_q;

	always_comb begin
		half_w  = w_q >> 1;
		up_w    = w_q - half_w;
		half_h  = h_q >> 1;
		up_h    = h_q - half_h;
		n       = (w_q > h_q) ? h_q : w_q;
		mid     = n >> 1;
		lastc   = n - CW'(1);
		k       = mid - CW'(lastc[0]);
		m       = full_q ? lastc : (lastc >> 1);
		top     = full_q ? (h_q - CW'(1)) : half_h;
		a       = k - i_q;
		b       = k - j_q;
		ns      = 2'd1;
		outer_n = '0;
		inner_n = '0;
		src_col = '0;
		src_row = '0;
		dst_col = '0;
		dst_row = '0;
		unique case (ph_q)
			PH_HORIZ: begin
				outer_n = top + CW'(1);
				inner_n = half_w;
				dst_col = up_w + j_q;
				dst_row = top - i_q;
				src_col = half_w - CW'(1) - j_q;
				src_row = top - i_q;
			end
			PH_VERT: begin
				outer_n = half_h;
				inner_n = w_q;
				dst_col = w_q - CW'(1) - j_q;
				dst_row = up_h + i_q;
				src_col = w_q - CW'(1) - j_q;
				src_row = half_h - CW'(1) - i_q;
			end
			PH_ROT: begin
				// three quarter turns of the top-left square, one per sub step
				outer_n = k + CW'(1);
				inner_n = k + CW'(1);
				ns      = 2'd3;
				src_col = a;
				src_row = b;
				if (s_q == 2'd0) begin
					dst_col = mid + b;
					dst_row = k - a;
				end else if (s_q == 2'd1) begin
					dst_col = lastc - a;
					dst_row = lastc - b;
				end else begin
					dst_col = k - b;
					dst_row = mid + a;
				end
			end
			PH_TRI_TOP: begin
				outer_n = m;
				inner_n = i_q + CW'(1);
				dst_col = i_q + CW'(1);
				dst_row = j_q;
				src_col = j_q;
				src_row = i_q + CW'(1);
			end
			PH_TRI_BOT: begin
				outer_n = m;
				inner_n = m - i_q;
				dst_col = m - i_q;
				dst_row = i_q + CW'(1) + j_q;
				src_col = m - i_q - CW'(1) - j_q;
				src_row = i_q;
			end
			default: begin
				outer_n = '0;
			end
		endcase
	end

	assign s_last = (s_q == ns - 2'd1);
	assign j_last = (j_q == inner_n - CW'(1));
	assign i_last = (i_q == outer_n - CW'(1));

	assign geo_stat.empty = (outer_n == '0) || (inner_n == '0);
	assign geo_stat.last  = s_last && j_last && i_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= CW'(clamp_dim(CFG_W'(DIM_RESET), MAX_WIDTH));
			h_q    <= CW'(clamp_dim(CFG_W'(DIM_RESET), MAX_HEIGHT));
			ph_q   <= PH_HORIZ;
			full_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
			s_q    <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_ACTIVE_WIDTH)
				w_q <= CW'(clamp_dim(cfg_data, MAX_WIDTH));
			if (cfg_we && cfg_index == REG_ACTIVE_HEIGHT)
				h_q <= CW'(clamp_dim(cfg_data, MAX_HEIGHT));
			if (cmd.g_init) begin
				ph_q   <= cmd.phase;
				full_q <= cmd.full;
				i_q    <= '0;
				j_q    <= '0;
				s_q    <= '0;
			end else if (cmd.g_step) begin
				if (!s_last) begin
					s_q <= s_q + 2'd1;
				end else begin
					s_q <= '0;
					if (!j_last) begin
						j_q <= j_q + CW'(1);
					end else begin
						j_q <= '0;
						i_q <= i_q + CW'(1);
					end
				end
			end
		end
	end

endmodule

### rtl/lfme_store.sv
// ----------------------------------------------------------------------------
// lfme_store
// Frame memory, spare cell, pixel read stage and result register.
// ----------------------------------------------------------------------------
module lfme_store import lfme_pkg::*; #(
	parameter  int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter  int MAX_HEIGHT = DEF_MAX_HEIGHT,
	localparam int CW = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ctl_cmd_t      cmd,
	input  in_item_t      in_data,
	input  logic [CW-1:0] act_w,
	input  logic [CW-1:0] act_h,
	input  logic [CW-1:0] src_col,
	input  logic [CW-1:0] src_row,
	input  logic [CW-1:0] dst_col,
	input  logic [CW-1:0] dst_row,
	output st_stat_t      st_stat,
	output logic          out_valid,
	input  logic          out_stall,
	output out_item_t     out_data
);

	localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int EW    = (CW > 7) ? CW : 7;

	logic [COLOR_W-1:0] mem [CELLS];
	logic [COLOR_W-1:0] rdata_q;
	logic [COLOR_W-1:0] spare_q;
	logic [AW-1:0]      clr_q;

	logic               rd_pend_s1, on_s1;
	logic [COLOR_W-1:0] spare_s1;
	logic               out_valid_q;
	out_item_t          out_q;

	logic               on;
	logic [CW-1:0]      px_col, px_row;
	logic               mem_we, mem_re;
	logic [AW-1:0]      waddr, raddr;
	logic [COLOR_W-1:0] wdata;
	logic               move;

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] col,
			input logic [CW-1:0] row);
		return AW'(AW'(row) * AW'(MAX_WIDTH) + AW'(col));
	endfunction

	assign on = !in_data.x[7] && !in_data.y[7] &&
	            (EW'(in_data.x[6:0]) < EW'(act_w)) &&
	            (EW'(in_data.y[6:0]) < EW'(act_h));
	assign px_col = CW'(in_data.x[6:0]);
	assign px_row = CW'(in_data.y[6:0]);

	always_comb begin
		mem_we = 1'b0;
		waddr  = cell_addr(dst_col, dst_row);
		wdata  = rdata_q;
		if (cmd.clr_wr) begin
			mem_we = 1'b1;
			waddr  = clr_q;
			wdata  = '0;
		end else if (cmd.px_wr) begin
			mem_we = on;
			waddr  = cell_addr(px_col, px_row);
			wdata  = in_data.color;
		end else if (cmd.mir_wr) begin
			mem_we = 1'b1;
		end
	end

	assign mem_re = cmd.mir_rd || (cmd.px_rd && on);
	assign raddr  = cmd.mir_rd ? cell_addr(src_col, src_row)
	                           : cell_addr(px_col, px_row);

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (mem_re) rdata_q <= mem[raddr];
	end

	// pending read result moves into the result register when it is free
	assign move             = rd_pend_s1 && (!out_valid_q || !out_stall);
	assign st_stat.blocked  = rd_pend_s1 && !move;
	assign st_stat.clr_last = (clr_q == AW'(CELLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			spare_q     <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + AW'(1);
			if (cmd.px_wr && !on) spare_q <= in_data.color;
			if (cmd.px_rd) rd_pend_s1 <= 1'b1;
			else if (move) rd_pend_s1 <= 1'b0;
			if (move) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.px_rd) begin
			on_s1    <= on;
			spare_s1 <= spare_q;
		end
		if (move) begin
			out_q.pixel_color <= on_s1 ? rdata_q : spare_s1;
			out_q.on_screen   <= on_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_no_read_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_pend_s1 && !move) |-> !cmd.px_rd)
		else $error("pixel read issued while result is held");

	a_clear_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !(cmd.px_wr || cmd.px_rd || cmd.mir_rd || cmd.mir_wr))
		else $error("access during clear sweep");

	a_read_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.px_rd |=> rd_pend_s1)
		else $error("pixel read lost");

	a_mirror_read_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mir_rd |-> !rd_pend_s1)
		else $error("mirror read would clobber pending pixel read");

endmodule

### rtl/led_frame_mirror_engine_unit.sv
// ----------------------------------------------------------------------------
// led_frame_mirror_engine_unit
// Frame store of RGB pixels with pixel write, pixel read and mirror commands.
// ----------------------------------------------------------------------------
// After reset the block sweeps the frame memory to zero, one cell a cycle,
// through all MAX_WIDTH*MAX_HEIGHT cells (1024 by default); in_stall stays
// high until the sweep ends. A pixel write takes one beat per cycle while no
// read result is held back. A pixel read takes one beat per cycle while
// results drain; its memory read is registered at the accepting edge, and the
// result moves on into the result register as soon as that register is free.
// A mirror command holds in_stall through a setup state per copy walk (one to
// three walks) and a read and a write state per copied pixel; an empty walk
// still passes through the read state. A full 32x32 left-to-right mirror
// copies 512 pixels. Off-screen accesses go to one spare cell. Width and
// height registers are to be written only while idle; no logic enforces it.
// ----------------------------------------------------------------------------
module led_frame_mirror_engine_unit import lfme_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CW = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);

	ctl_cmd_t      cmd;
	st_stat_t      st_stat;
	geo_stat_t     geo_stat;
	logic [CW-1:0] act_w, act_h;
	logic [CW-1:0] src_col, src_row, dst_col, dst_row;

	// controller: clear sweep, handshake, mirror phase order
	lfme_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.st_stat  (st_stat),
		.geo_stat (geo_stat),
		.cmd      (cmd)
	);

	// active size and copy coordinates
	lfme_geom #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.geo_stat  (geo_stat),
		.act_w     (act_w),
		.act_h     (act_h),
		.src_col   (src_col),
		.src_row   (src_row),
		.dst_col   (dst_col),
		.dst_row   (dst_row)
	);

	// frame memory and result register
	lfme_store #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.act_w     (act_w),
		.act_h     (act_h),
		.src_col   (src_col),
		.src_row   (src_row),
		.dst_col   (dst_col),
		.dst_row   (dst_row),
		.st_stat   (st_stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### test/tb_led_frame_mirror_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_frame_mirror_engine_unit
// Self-checking bench for the LED frame mirror engine.
// ----------------------------------------------------------------------------
// A class keeps its own copy of the frame store, the spare cell and the size
// registers, replays every accepted beat on that copy and queues the expected
// read results. Plain tasks drive pixel writes, reads and mirror commands under
// several frame sizes, with random gaps on both sides, one long output stall
// and full drains before each size change.
// ----------------------------------------------------------------------------
module tb_led_frame_mirror_engine_unit;
	import lfme_pkg::*;

	localparam int MW = DEF_MAX_WIDTH;
	localparam int MH = DEF_MAX_HEIGHT;
	localparam int ITEMS_PER_SIZE = 150;
	localparam int SETTLE_CYCLES  = 4000;  // longest mirror walk, with margin

	// shadow frame store and the reads it predicts
	class frame_scoreboard;
		logic [COLOR_W-1:0] pixels [MW*MH];
		logic [COLOR_W-1:0] spare;
		logic [CFG_W-1:0]   width_reg;
		logic [CFG_W-1:0]   height_reg;
		out_item_t          pending_reads [$];
		int                 mismatches;

		function new();
			foreach (pixels[i]) pixels[i] = '0;
			spare = '0;
			width_reg = CFG_W'(DIM_RESET);
			height_reg = CFG_W'(DIM_RESET);
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_ACTIVE_WIDTH) width_reg = val;
			else if (idx == REG_ACTIVE_HEIGHT) height_reg = val;
		endfunction

		function int eff_w();
			if (width_reg == 0) return 1;
			return (width_reg > MW) ? MW : int'(width_reg);
		endfunction

		function int eff_h();
			if (height_reg == 0) return 1;
			return (height_reg > MH) ? MH : int'(height_reg);
		endfunction

		function int side();
			return (eff_w() > eff_h()) ? eff_h() : eff_w();
		endfunction

		// in-place copy; anything outside the store is dropped
		function void copy_px(int dc, int dr, int sc, int sr);
			if (dc < 0 || dc >= MW || dr < 0 || dr >= MH) return;
			if (sc < 0 || sc >= MW || sr < 0 || sr >= MH) return;
			pixels[dr*MW + dc] = pixels[sr*MW + sc];
		endfunction

		function void flip_lr(bit full);
			int w, r, a, b;
			w = eff_w();
			for (r = full ? eff_h() - 1 : eff_h() / 2; r >= 0; r--) begin
				b = (w + 1) / 2;
				for (a = w / 2 - 1; a >= 0; a--) begin
					copy_px(b, r, a, r);
					b++;
				end
			end
		endfunction

		function void flip_tb();
			int h, a, b, c;
			h = eff_h();
			b = (h + 1) / 2;
			for (a = h / 2 - 1; a >= 0; a--) begin
				for (c = eff_w() - 1; c >= 0; c--) copy_px(c, b, c, a);
				b++;
			end
		endfunction

		function void rotate_quads();
			int n, mid, last, odd, a, b;
			n = side();
			mid = n / 2;
			last = n - 1;
			odd = last % 2;
			for (a = mid - odd; a >= 0; a--)
				for (b = mid - odd; b >= 0; b--) begin
					copy_px(mid + b, mid - odd - a, a, b);
					copy_px(last - a, last - b, a, b);
					copy_px(mid - odd - b, mid + a, a, b);
				end
		endfunction

		function void tri_upper(bit full);
			int m, r, c;
			m = side() - 1;
			if (!full) m = m / 2;
			for (r = 1; r <= m; r++)
				for (c = 0; c < r; c++) copy_px(r, c, c, r);
		endfunction

		function void tri_lower(bit full);
			int m, r, dc, c, dr;
			m = side() - 1;
			if (!full) m = m / 2;
			dc = m;
			for (r = 0; r < m; r++) begin
				dr = r + 1;
				for (c = m - r - 1; c >= 0; c--) begin
					copy_px(dc, dr, c, r);
					dr++;
				end
				dc--;
			end
		endfunction

		function void note_item(in_item_t it);
			int x, y;
			bit on;
			out_item_t res;
			x = int'(it.x);
			y = int'(it.y);
			on = x >= 0 && x < eff_w() && y >= 0 && y < eff_h();
			case (op_t'(it.op))
				OP_WRITE: begin
					if (on) pixels[y*MW + x] = it.color;
					else spare = it.color;
				end
				OP_READ: begin
					res.pixel_color = on ? pixels[y*MW + x] : spare;
					res.on_screen = on;
					pending_reads.push_back(res);
				end
				OP_MIRROR: begin
					case (mode_t'(it.mode))
						MODE_HORIZ:    flip_lr(it.full_height);
						MODE_VERT:     flip_tb();
						MODE_QUAD:     begin flip_lr(0); flip_tb(); end
						MODE_QUAD_ROT: rotate_quads();
						MODE_TRI_TOP:  tri_upper(it.full_height);
						MODE_TRI_BOT:  tri_lower(it.full_height);
						MODE_QUAD_TRI_TOP: begin
							tri_upper(0); flip_lr(0); flip_tb();
						end
						default: begin
							tri_lower(0); flip_lr(0); flip_tb();
						end
					endcase
				end
				default: ;  // no-op code: nothing changes
			endcase
		endfunction

		function void check_pixel(out_item_t got);
			out_item_t want;
			if (pending_reads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: color %h on %b",
						got.pixel_color, got.on_screen);
				return;
			end
			want = pending_reads.pop_front();
			if (got.pixel_color !== want.pixel_color || got.on_screen !== want.on_screen) begin
				mismatches++;
				if (mismatches <= 10)
					$display("read mismatch: expected color %h on %b, got color %h on %b",
						want.pixel_color, want.on_screen, got.pixel_color, got.on_screen);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	frame_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold_left;
	int beats_sent;

	led_frame_mirror_engine_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#50_000_000;
		$display("FAILURE");
		$finish;
	end

	// both beats are sampled at the rising edge, input first
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) sb.note_item(in_data);
		if (arst_n && out_valid && !out_stall) sb.check_pixel(out_data);
	end

	// result side: random stalls, or a long counted hold-off when requested
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			out_stall <= 1'b1;
			rx_hold_left <= rx_hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// one beat; called at a falling edge, returns at a falling edge
	task automatic send_beat(in_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		beats_sent++;
		// idle mix moves with progress: receiver-heavy, sender-heavy, none
		if (beats_sent < 450) begin
			tx_idle_pct = 32; rx_idle_pct = 72;
		end else if (beats_sent < 900) begin
			tx_idle_pct = 72; rx_idle_pct = 32;
		end else begin
			tx_idle_pct = 0; rx_idle_pct = 0;
		end
	endtask

	// wait for every read to come back, then for any mirror walk to finish
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_reads.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		sb.set_reg(idx, val);
		cfg_we <= 1'b0;
	endtask

	function automatic in_item_t make_item(op_t op, int x, int y, mode_t mode, bit full);
		in_item_t it;
		it.op = op;
		it.x = 8'(x);
		it.y = 8'(y);
		it.color = 24'($urandom);
		it.mode = mode;
		it.full_height = full;
		return it;
	endfunction

	// mostly on-screen coordinates with a ring just outside; sometimes anything
	function automatic int pick_coord(int lim);
		if ($urandom_range(9) == 0) return int'($signed(8'($urandom)));
		return $urandom_range(lim + 1) - 1;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int pick;
		op_t op;
		pick = $urandom_range(99);
		if (pick < 45) op = OP_WRITE;
		else if (pick < 90) op = OP_READ;
		else if (pick < 97) op = OP_MIRROR;
		else op = OP_NOP;
		it = make_item(op, pick_coord(sb.eff_w()), pick_coord(sb.eff_h()),
			mode_t'($urandom_range(7)), $urandom_range(1));
		return it;
	endfunction

	task automatic directed_part();
		int w, h, m;
		w = sb.eff_w();
		h = sb.eff_h();
		// corners, then the signed extremes that land on the spare cell
		send_beat(make_item(OP_WRITE, 0, 0, MODE_HORIZ, 0));
		send_beat(make_item(OP_WRITE, w - 1, h - 1, MODE_HORIZ, 0));
		send_beat(make_item(OP_WRITE, w - 1, 0, MODE_HORIZ, 0));
		send_beat(make_item(OP_WRITE, -128, 127, MODE_HORIZ, 0));
		send_beat(make_item(OP_READ, 0, 0, MODE_HORIZ, 0));
		send_beat(make_item(OP_READ, w - 1, h - 1, MODE_HORIZ, 0));
		send_beat(make_item(OP_READ, 127, -128, MODE_HORIZ, 0));
		send_beat(make_item(OP_READ, -1, 0, MODE_HORIZ, 0));
		send_beat(make_item(OP_READ, w, h - 1, MODE_HORIZ, 0));
		send_beat(make_item(OP_NOP, 0, 0, MODE_HORIZ, 0));
		// every mirror mode, size flag from the mode's low bit, each followed by a read
		for (m = 0; m < 8; m++) begin
			send_beat(make_item(OP_MIRROR, 0, 0, mode_t'(m), m[0]));
			send_beat(make_item(OP_READ, w - 1, h - 1, MODE_HORIZ, 0));
		end
		send_beat(make_item(OP_MIRROR, 0, 0, MODE_HORIZ, 1));
		send_beat(make_item(OP_MIRROR, 0, 0, MODE_TRI_TOP, 0));
		send_beat(make_item(OP_MIRROR, 0, 0, MODE_TRI_BOT, 1));
	endtask

	initial begin
		logic [CFG_W-1:0] widths  [9] = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd5, 6'd32, 6'd13, 6'd2, 6'd31};
		logic [CFG_W-1:0] heights [9] = '{6'd32, 6'd63, 6'd0, 6'd1, 6'd7, 6'd17, 6'd32, 6'd32, 6'd3};
		int s, i;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ACTIVE_WIDTH;
		cfg_data = '0;
		tx_idle_pct = 32;
		rx_idle_pct = 72;
		rx_hold_left = 0;
		beats_sent = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		directed_part();
		for (s = 0; s < 9; s++) begin
			if (s > 0) begin
				drain();
				write_reg(REG_ACTIVE_WIDTH, widths[s]);
				write_reg(REG_ACTIVE_HEIGHT, heights[s]);
			end
			if (s == 2) begin
				// long output hold-off while reads keep coming: the block backs up
				rx_hold_left = 400;
				for (i = 0; i < 40; i++)
					send_beat(make_item(OP_READ, pick_coord(sb.eff_w()),
						pick_coord(sb.eff_h()), MODE_HORIZ, 0));
			end
			if (s == 5) directed_part();
			for (i = 0; i < ITEMS_PER_SIZE; i++) send_beat(random_item());
		end
		in_valid <= 1'b0;

		while (sb.pending_reads.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending_reads.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
